@@ rtl/bws_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 3x3 block weight smoother.
// Depends on nothing; imported by block_weight_smooth_3x3_core.
package bws_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SUM_W     = 20;
	localparam int ROW_W     = 12;
	localparam int OCOL_W    = 8;
	localparam int GW_W      = 9;
	localparam int GH_W      = 13;
	localparam int CFG_W     = 13;
	localparam int MAX_ROWS  = 4096;
	localparam int NRES      = 4;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 40;

	// reciprocal of 3 scaled by 2^19, exact for dividends below 2^19
	localparam int RECIP3    = 174763;
	localparam int RECIP3_SH = 19;

	// configuration register indexes
	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	// one column of the window: rows R-2, R-1 and R
	typedef struct packed {
		logic [SAMPLE_W-1:0] r0;
		logic [SAMPLE_W-1:0] r1;
		logic [SAMPLE_W-1:0] r2;
	} triple_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] top;
		logic [SAMPLE_W-1:0] mid;
		logic [SAMPLE_W-1:0] bot;
	} taps_t;

	// one result item as held in the output queue
	typedef struct packed {
		logic                last;
		logic [OCOL_W-1:0]   col;
		logic [ROW_W-1:0]    row;
		logic [SAMPLE_W-1:0] val;
	} res_t;

	// vertical taps of one column, replicating the top and bottom edges
	function automatic taps_t col_taps(triple_t c, logic last_row, logic r_is_one,
			logic r_is_zero);
		taps_t t;
		if (!last_row) begin
			t.top = r_is_one ? c.r1 : c.r0;
			t.mid = c.r1;
			t.bot = c.r2;
		end else begin
			t.top = r_is_zero ? c.r2 : c.r1;
			t.mid = c.r2;
			t.bot = c.r2;
		end
		return t;
	endfunction

	// weighted 3x3 sum: centre counts four times
	function automatic logic [SUM_W-1:0] win_sum(triple_t l, triple_t c, triple_t rt,
			logic last_row, logic r_is_one, logic r_is_zero);
		taps_t tl;
		taps_t tc;
		taps_t tr;
		logic [SUM_W-1:0] s;
		tl = col_taps(l, last_row, r_is_one, r_is_zero);
		tc = col_taps(c, last_row, r_is_one, r_is_zero);
		tr = col_taps(rt, last_row, r_is_one, r_is_zero);
		s = SUM_W'(tl.top) + SUM_W'(tl.mid) + SUM_W'(tl.bot)
		  + SUM_W'(tr.top) + SUM_W'(tr.mid) + SUM_W'(tr.bot)
		  + SUM_W'(tc.top) + SUM_W'(tc.bot) + SUM_W'({tc.mid, 2'b00});
		return s;
	endfunction

	// (sum + 6) / 12: drop two bits, then multiply by the reciprocal of 3
	function automatic logic [SAMPLE_W-1:0] div12_round(logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] n;
		logic [SUM_W-3:0] m;
		logic [35:0]      p;
		n = s + SUM_W'(6);
		m = n[SUM_W-1:2];
		p = 36'(m) * 36'(RECIP3);
		return p[RECIP3_SH+SAMPLE_W-1:RECIP3_SH];
	endfunction

endpackage

@@ rtl/block_weight_smooth_3x3_core.sv @@
// Top level of the 3x3 block weight smoother: line store, window, two-stage
// arithmetic pipe and result queue. Depends on bws_pkg.
//
// Smooths a raster stream of Q0.16 block weights with a 3x3 kernel (centre
// weight 4, neighbours 1, divided by 12, rounded half up), replicating edge
// samples at the grid border. One item is taken per clock while s_tready is
// high; the results of an item pass the stage 1 and stage 2 registers and
// are then written into the result queue. Results leave at one per clock
// while m_tready is high, so outside the last row the input runs at full
// rate (at most two results per item, and those only at the row end); in the
// last row an item gives up to four results; the input is paced by the
// output port. s_tready drops when the 16-entry result queue cannot take four
// results for every item in the pipe plus one more. Results for a row appear
// once the row below has arrived; the last output of a frame carries m_tlast.
// Writing grid_width or grid_height restarts the frame; do so only when idle.
module block_weight_smooth_3x3_core #(
	parameter int MAX_COLS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bws_pkg::CFG_W-1:0]     cfg_data,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bws_pkg::IN_DATA_W-1:0] s_tdata,  // weight_sample[15:0]
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bws_pkg::OUT_DATA_W-1:0] m_tdata, // smoothed_weight[15:0],
	                                                // out_row[27:16], out_col[35:28]
	output logic                          m_tlast   // frame_last
);
	import bws_pkg::*;

	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int Q_DEPTH = 16;
	localparam int QA_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = QA_W + 1;

	// configuration registers
	logic [GW_W-1:0] grid_width_q;
	logic [GH_W-1:0] grid_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GW_W'(80);
			grid_height_q <= GH_W'(45);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[GW_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[GH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped grid size, as last column and last row
	logic [31:0]      w_eff;
	logic [31:0]      h_eff;
	logic [COL_W-1:0] wlast;
	logic [ROW_W-1:0] hlast;

	always_comb begin
		if (grid_width_q == '0)
			w_eff = 32'd1;
		else if (32'(grid_width_q) > 32'(MAX_COLS))
			w_eff = 32'(MAX_COLS);
		else
			w_eff = 32'(grid_width_q);
		if (grid_height_q == '0)
			h_eff = 32'd1;
		else if (32'(grid_height_q) > 32'(MAX_ROWS))
			h_eff = 32'(MAX_ROWS);
		else
			h_eff = 32'(grid_height_q);
		wlast = COL_W'(w_eff - 32'd1);
		hlast = ROW_W'(h_eff - 32'd1);
	end

	// pipeline occupancy and flow control
	logic            valid_s1;
	logic            valid_s2;
	logic [QC_W-1:0] q_count_q;
	logic [QC_W+1:0] q_need;
	logic            in_acc;
	logic            out_acc;

	assign q_need   = (QC_W+2)'(q_count_q) + (QC_W+2)'(NRES)
	                + (QC_W+2)'(NRES) * (QC_W+2)'({1'b0, valid_s1})
	                + (QC_W+2)'(NRES) * (QC_W+2)'({1'b0, valid_s2});
	assign s_tready = (q_need <= (QC_W+2)'(Q_DEPTH));
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (q_count_q != '0);
	assign out_acc  = m_tvalid && m_tready;

	// input position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             end_col;
	logic             last_row;

	assign end_col  = (col_q == wlast);
	assign last_row = (row_q == hlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// stage 1 control: position of the item whose line data is being read
	logic             end_s1;
	logic             lrow_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [SAMPLE_W-1:0] x_s1;
	logic             byp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			byp_s1   <= in_acc && valid_s1 && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1  <= col_q;
			row_s1  <= row_q;
			end_s1  <= end_col;
			lrow_s1 <= last_row;
			x_s1    <= s_tdata[SAMPLE_W-1:0];
		end
	end

	// line store: one word per column, upper row low half, middle row high half
	logic [2*SAMPLE_W-1:0] line_mem [MAX_COLS];
	logic [2*SAMPLE_W-1:0] rd_s1;
	logic [2*SAMPLE_W-1:0] byp_data_s1;
	logic [2*SAMPLE_W-1:0] word_s1;
	logic [2*SAMPLE_W-1:0] wr_word;

	assign word_s1 = byp_s1 ? byp_data_s1 : rd_s1;
	assign wr_word = {x_s1, word_s1[2*SAMPLE_W-1:SAMPLE_W]};

	always_ff @(posedge clk) begin
		if (in_acc)
			rd_s1 <= line_mem[col_q];
		if (valid_s1)
			line_mem[col_s1] <= wr_word;
	end

	// same column read and written at one edge: forward the new word
	always_ff @(posedge clk) begin
		if (valid_s1)
			byp_data_s1 <= wr_word;
	end

	// column window: two previous columns of the current row
	triple_t cur_s1;
	triple_t win0_q;
	triple_t win1_q;

	assign cur_s1 = '{r0: word_s1[SAMPLE_W-1:0], r1: word_s1[2*SAMPLE_W-1:SAMPLE_W],
	                  r2: x_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (cfg_we) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (valid_s1) begin
			win0_q <= win1_q;
			win1_q <= cur_s1;
		end
	end

	// stage 1 arithmetic: up to four weighted sums in emission order
	logic            c_ge1;
	logic            c_ge2;
	logic            r_ge1;
	logic            r_is_one;
	logic            r_is_zero;
	triple_t         left_a;
	triple_t         left_b;
	logic [NRES-1:0] emit_s1;
	logic [SUM_W-1:0] sum_s1 [NRES];
	res_t            meta_s1 [NRES];
	logic [31:0]     col_ext;
	logic [31:0]     colm1_ext;
	logic [OCOL_W-1:0] col8;
	logic [OCOL_W-1:0] colm1_8;
	logic [ROW_W-1:0]  rowm1;

	always_comb begin
		c_ge1     = (col_s1 != '0);
		c_ge2     = (col_s1 > COL_W'(1));
		r_ge1     = (row_s1 != '0);
		r_is_one  = (row_s1 == ROW_W'(1));
		r_is_zero = (row_s1 == '0);
		left_a    = c_ge2 ? win0_q : win1_q;
		left_b    = c_ge1 ? win1_q : cur_s1;
		col_ext   = 32'(col_s1);
		colm1_ext = 32'(col_s1 - COL_W'(1));
		col8      = col_ext[OCOL_W-1:0];
		colm1_8   = colm1_ext[OCOL_W-1:0];
		rowm1     = row_s1 - ROW_W'(1);

		emit_s1[0] = r_ge1 && c_ge1;
		emit_s1[1] = r_ge1 && end_s1;
		emit_s1[2] = lrow_s1 && c_ge1;
		emit_s1[3] = lrow_s1 && end_s1;

		sum_s1[0] = win_sum(left_a, win1_q, cur_s1, 1'b0, r_is_one, r_is_zero);
		sum_s1[1] = win_sum(left_b, cur_s1, cur_s1, 1'b0, r_is_one, r_is_zero);
		sum_s1[2] = win_sum(left_a, win1_q, cur_s1, 1'b1, r_is_one, r_is_zero);
		sum_s1[3] = win_sum(left_b, cur_s1, cur_s1, 1'b1, r_is_one, r_is_zero);

		meta_s1[0] = '{last: 1'b0, col: colm1_8, row: rowm1,  val: '0};
		meta_s1[1] = '{last: 1'b0, col: col8,    row: rowm1,  val: '0};
		meta_s1[2] = '{last: 1'b0, col: colm1_8, row: row_s1, val: '0};
		meta_s1[3] = '{last: 1'b1, col: col8,    row: row_s1, val: '0};
	end

	// stage 2 registers
	logic [NRES-1:0]  emit_s2;
	logic [SUM_W-1:0] sum_s2 [NRES];
	res_t             meta_s2 [NRES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			emit_s2  <= '0;
		end else begin
			valid_s2 <= valid_s1;
			emit_s2  <= valid_s1 ? emit_s1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int k = 0; k < NRES; k++) begin
				sum_s2[k]  <= sum_s1[k];
				meta_s2[k] <= meta_s1[k];
			end
		end
	end

	// stage 2: divide and pack the valid results
	res_t            res_s2 [NRES];
	logic [QA_W-1:0] off_s2 [NRES];
	logic [2:0]      push_n;

	always_comb begin
		push_n = '0;
		for (int k = 0; k < NRES; k++) begin
			res_s2[k]     = meta_s2[k];
			res_s2[k].val = div12_round(sum_s2[k]);
			off_s2[k]     = QA_W'(push_n);
			push_n        = push_n + 3'(emit_s2[k]);
		end
	end

	// result queue
	res_t            q_mem [Q_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	res_t            q_head;

	always_ff @(posedge clk) begin
		for (int k = 0; k < NRES; k++) begin
			if (emit_s2[k])
				q_mem[wr_ptr_q + off_s2[k]] <= res_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			q_count_q <= '0;
		end else begin
			wr_ptr_q  <= wr_ptr_q + QA_W'(push_n);
			rd_ptr_q  <= rd_ptr_q + QA_W'(out_acc);
			q_count_q <= q_count_q + QC_W'(push_n) - QC_W'(out_acc);
		end
	end

	assign q_head  = q_mem[rd_ptr_q];
	assign m_tdata = {4'b0000, q_head.col, q_head.row, q_head.val};
	assign m_tlast = q_head.last;

	// checks
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(QC_W+1)'(q_count_q) + (QC_W+1)'(push_n) <= (QC_W+1)'(Q_DEPTH))
		else $error("result queue overflow");

	a_byp_src: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> valid_s1 && $past(valid_s1))
		else $error("forwarding without a preceding item");

	a_emit_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s2 != '0) |-> valid_s2)
		else $error("result from an empty stage");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (q_head.row == hlast))
		else $error("frame end marked off the last row");

	a_stage_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("stage 2 loaded without stage 1");

endmodule
